>>> sv/indexed_list_engine_defines.svh
// Assertion macros shared by the list engine RTL.
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ILE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ILE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ile_pkg.sv
// Types and constants shared by the list engine top level and its cells.
package ile_pkg;

    // Index and count widths cover the largest supported capacity of 256.
    localparam int IDX_W = 8;
    localparam int CNT_W = 9;

    // Command codes of the mode field.
    localparam logic [3:0] MODE_PUSH_BACK  = 4'd0;
    localparam logic [3:0] MODE_PUSH_FRONT = 4'd1;
    localparam logic [3:0] MODE_INSERT     = 4'd2;
    localparam logic [3:0] MODE_POP_BACK   = 4'd3;
    localparam logic [3:0] MODE_POP_FRONT  = 4'd4;
    localparam logic [3:0] MODE_REMOVE     = 4'd5;
    localparam logic [3:0] MODE_SET        = 4'd6;
    localparam logic [3:0] MODE_GET        = 4'd7;
    localparam logic [3:0] MODE_SEARCH     = 4'd8;
    localparam logic [3:0] MODE_CLEAR      = 4'd9;

    // Status codes returned with every result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // Operation carried out by the cells as the command walks the chain.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_INS,
        OP_DEL,
        OP_SET,
        OP_GET,
        OP_FIND
    } t_op;

    // Command broadcast to all cells for the length of one pass.
    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] at;
        logic [CNT_W-1:0] lim;
    } t_ctl;

    // Token handed from cell to cell, one cell per cycle.
    typedef struct packed {
        logic             vld;
        logic             found;
        logic [IDX_W-1:0] fidx;
    } t_tok;

    // Input beat.
    typedef struct packed {
        logic [3:0]         mode;
        logic [4:0]         position;
        logic signed [31:0] value;
    } t_in_item;

    // Output beat.
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data_out;
        logic               found;
        logic [3:0]         found_index;
        logic [4:0]         count;
    } t_out_item;

endpackage

>>> sv/ile_cell.sv
// One list cell: holds the element at a fixed position and acts on the passing command token.
module ile_cell #(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ile_pkg::t_ctl         i_ctl,
    input  logic [DATA_WIDTH-1:0] i_key,
    input  ile_pkg::t_tok         i_tok,
    input  logic [DATA_WIDTH-1:0] i_carry,
    input  logic [DATA_WIDTH-1:0] i_rdata,
    input  logic [DATA_WIDTH-1:0] i_next,
    output ile_pkg::t_tok         o_tok,
    output logic [DATA_WIDTH-1:0] o_carry,
    output logic [DATA_WIDTH-1:0] o_rdata,
    output logic [DATA_WIDTH-1:0] o_elem
);

    localparam logic [ile_pkg::CNT_W-1:0] MY_IDX = ile_pkg::CNT_W'(IDX);

    logic [DATA_WIDTH-1:0]     r_elem;
    logic [DATA_WIDTH-1:0]     n_elem;
    logic [DATA_WIDTH-1:0]     r_carry;
    logic [DATA_WIDTH-1:0]     n_carry;
    logic [DATA_WIDTH-1:0]     r_rdata;
    logic [DATA_WIDTH-1:0]     n_rdata;
    ile_pkg::t_tok             r_tok;
    ile_pkg::t_tok             n_tok;
    logic [ile_pkg::CNT_W-1:0] w_at;

    assign w_at = {1'b0, i_ctl.at};

    // Per-cell action while the token sits at this position.
    always_comb begin
        n_elem  = r_elem;
        n_carry = i_carry;
        n_rdata = i_rdata;
        n_tok   = i_tok;
        if (i_tok.vld) begin
            unique case (i_ctl.op)
                ile_pkg::OP_INS: begin
                    // Insertion point takes the key; later cells shift right by one.
                    if (MY_IDX == w_at) begin
                        n_elem  = i_key;
                        n_carry = r_elem;
                    end else if (MY_IDX > w_at) begin
                        n_elem  = i_carry;
                        n_carry = r_elem;
                    end
                end
                ile_pkg::OP_DEL: begin
                    // The right neighbor has not been visited yet, so it still holds its value.
                    if (MY_IDX >= w_at) begin
                        n_elem = i_next;
                    end
                    if (MY_IDX == w_at) begin
                        n_rdata = r_elem;
                    end
                end
                ile_pkg::OP_SET: begin
                    if (MY_IDX == w_at) begin
                        n_elem = i_key;
                    end
                end
                ile_pkg::OP_GET: begin
                    if (MY_IDX == w_at) begin
                        n_rdata = r_elem;
                    end
                end
                ile_pkg::OP_FIND: begin
                    // Only the first stored match is reported.
                    if (!i_tok.found && MY_IDX < i_ctl.lim && r_elem == i_key) begin
                        n_tok.found = 1'b1;
                        n_tok.fidx  = MY_IDX[ile_pkg::IDX_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Token valid is control state; data registers need no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_elem  <= n_elem;
        r_carry <= n_carry;
        r_rdata <= n_rdata;
    end

    assign o_tok   = r_tok;
    assign o_carry = r_carry;
    assign o_rdata = r_rdata;
    assign o_elem  = r_elem;

endmodule

>>> sv/indexed_list_engine.sv
// Top level of the bounded ordered list engine built as a chain of element cells.
//
// Usage: one command beat enters on the input channel (mode, position, value) and
// exactly one result beat (status, data_out, found, found_index, count) leaves on
// the output channel for it, in order. Both channels use valid/ready.
// The status and the new count are settled when the command is accepted; the command
// then walks the cell chain one cell per cycle, each cell shifting, writing, reading
// or matching its own element as the token passes.
// The command passes the launch register, then the token register of each cell in order,
// and the result is then registered in the output register. The next command is taken
// only after the token has left the cell chain.
// Output stall: a finished result waits in the output register and a second result
// may wait in a holding slot, so a command is accepted while a result is still
// waiting; new commands also stop when both slots are full.
// Reset: synchronous, active low; the list is empty afterwards and no clearing pass
// is needed, because element contents beyond the count are never observed.
module indexed_list_engine #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ile_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ile_pkg::t_out_item  o_out_data
);

    `include "indexed_list_engine_defines.svh"

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [ile_pkg::CNT_W-1:0] CAP_CNT = ile_pkg::CNT_W'(CAPACITY);

    // Control and result registers.
    logic                  r_busy;
    logic                  r_launch;
    logic [CW-1:0]         r_count;
    logic [1:0]            r_status;
    ile_pkg::t_ctl         r_ctl;
    logic [DATA_WIDTH-1:0] r_key;
    logic                  r_out_vld;
    ile_pkg::t_out_item    r_out;
    logic                  r_pend_vld;
    ile_pkg::t_out_item    r_pend;

    // Decode results for the beat being offered.
    logic [1:0]                n_status;
    ile_pkg::t_op              n_op;
    logic [ile_pkg::CNT_W-1:0] n_at;
    logic [CW-1:0]             n_count;
    logic [ile_pkg::CNT_W-1:0] w_cnt;
    logic [ile_pkg::CNT_W-1:0] w_pos;
    logic [63:0]               w_val64;
    logic [DATA_WIDTH-1:0]     w_key;
    logic                      w_in_fire;

    // Cell chain wiring.
    ile_pkg::t_tok         w_tok   [CAPACITY];
    logic [DATA_WIDTH-1:0] w_carry [CAPACITY];
    logic [DATA_WIDTH-1:0] w_rdata [CAPACITY];
    logic [DATA_WIDTH-1:0] w_elem  [CAPACITY];
    logic [CAPACITY-1:0]   w_tok_vld;
    logic [CAPACITY:0]     w_chain_vld;

    // Result assembled as the token leaves the last cell.
    logic                  w_exit;
    logic signed [63:0]    w_wide;
    ile_pkg::t_out_item    w_res;

    assign o_in_ready = !r_busy && !r_pend_vld;
    assign w_in_fire  = i_in_valid && o_in_ready;

    assign w_cnt   = ile_pkg::CNT_W'(r_count);
    assign w_pos   = ile_pkg::CNT_W'(i_in_data.position);
    assign w_val64 = {32'b0, i_in_data.value};
    assign w_key   = w_val64[DATA_WIDTH-1:0];

    // Command decode: status and count follow from the mode, the position and the current count.
    always_comb begin
        n_status = ile_pkg::ST_OK;
        n_op     = ile_pkg::OP_NOP;
        n_at     = '0;
        n_count  = r_count;
        unique case (i_in_data.mode)
            ile_pkg::MODE_PUSH_BACK, ile_pkg::MODE_PUSH_FRONT: begin
                if (w_cnt >= CAP_CNT) begin
                    n_status = ile_pkg::ST_FULL;
                end else begin
                    n_op    = ile_pkg::OP_INS;
                    n_at    = (i_in_data.mode == ile_pkg::MODE_PUSH_BACK) ? w_cnt : '0;
                    n_count = CW'(w_cnt + 1'b1);
                end
            end
            ile_pkg::MODE_INSERT: begin
                if (w_pos > w_cnt) begin
                    n_status = ile_pkg::ST_RANGE;
                end else if (w_cnt >= CAP_CNT) begin
                    n_status = ile_pkg::ST_FULL;
                end else begin
                    n_op    = ile_pkg::OP_INS;
                    n_at    = w_pos;
                    n_count = CW'(w_cnt + 1'b1);
                end
            end
            ile_pkg::MODE_POP_BACK, ile_pkg::MODE_POP_FRONT: begin
                if (w_cnt == '0) begin
                    n_status = ile_pkg::ST_EMPTY;
                end else begin
                    n_op    = ile_pkg::OP_DEL;
                    n_at    = (i_in_data.mode == ile_pkg::MODE_POP_BACK) ? w_cnt - 1'b1 : '0;
                    n_count = CW'(w_cnt - 1'b1);
                end
            end
            ile_pkg::MODE_REMOVE: begin
                if (w_pos >= w_cnt) begin
                    n_status = ile_pkg::ST_RANGE;
                end else begin
                    n_op    = ile_pkg::OP_DEL;
                    n_at    = w_pos;
                    n_count = CW'(w_cnt - 1'b1);
                end
            end
            ile_pkg::MODE_SET, ile_pkg::MODE_GET: begin
                if (w_pos >= w_cnt) begin
                    n_status = ile_pkg::ST_RANGE;
                end else begin
                    n_op = (i_in_data.mode == ile_pkg::MODE_SET) ? ile_pkg::OP_SET
                                                                  : ile_pkg::OP_GET;
                    n_at = w_pos;
                end
            end
            ile_pkg::MODE_SEARCH: begin
                n_op = ile_pkg::OP_FIND;
            end
            ile_pkg::MODE_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // Cell chain: each cell takes the token from its left neighbor.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        ile_pkg::t_tok         w_tok_in;
        logic [DATA_WIDTH-1:0] w_carry_in;
        logic [DATA_WIDTH-1:0] w_rdata_in;
        logic [DATA_WIDTH-1:0] w_next;

        if (gi == 0) begin : g_head
            assign w_tok_in   = '{vld: r_launch, found: 1'b0, fidx: '0};
            assign w_carry_in = '0;
            assign w_rdata_in = '0;
        end else begin : g_body
            assign w_tok_in   = w_tok[gi-1];
            assign w_carry_in = w_carry[gi-1];
            assign w_rdata_in = w_rdata[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_tail
            assign w_next = w_elem[gi];
        end else begin : g_mid
            assign w_next = w_elem[gi+1];
        end

        ile_cell #(
            .IDX        (gi),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (r_ctl),
            .i_key   (r_key),
            .i_tok   (w_tok_in),
            .i_carry (w_carry_in),
            .i_rdata (w_rdata_in),
            .i_next  (w_next),
            .o_tok   (w_tok[gi]),
            .o_carry (w_carry[gi]),
            .o_rdata (w_rdata[gi]),
            .o_elem  (w_elem[gi])
        );

        assign w_tok_vld[gi] = w_tok[gi].vld;
    end

    assign w_chain_vld = {w_tok_vld, r_launch};

    // Result beat from the token leaving the last cell.
    assign w_exit = w_tok[CAPACITY-1].vld;
    assign w_wide = 64'($signed(w_rdata[CAPACITY-1]));

    always_comb begin
        w_res.status      = r_status;
        w_res.data_out    = w_wide[31:0];
        w_res.found       = w_tok[CAPACITY-1].found;
        w_res.found_index = w_tok[CAPACITY-1].fidx[3:0];
        w_res.count       = 5'(r_count);
    end

    // Command acceptance, launch and result slots.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_launch   <= 1'b0;
            r_count    <= '0;
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_ctl      <= '{op: ile_pkg::OP_NOP, at: '0, lim: '0};
        end else begin
            r_launch <= w_in_fire;
            if (w_in_fire) begin
                r_busy   <= 1'b1;
                r_count  <= n_count;
                r_status <= n_status;
                r_ctl    <= '{op: n_op, at: n_at[ile_pkg::IDX_W-1:0], lim: w_cnt};
                r_key    <= w_key;
            end else if (w_exit) begin
                r_busy <= 1'b0;
            end

            if (w_exit) begin
                if (!r_out_vld || i_out_ready) begin
                    r_out     <= w_res;
                    r_out_vld <= 1'b1;
                end else begin
                    r_pend     <= w_res;
                    r_pend_vld <= 1'b1;
                end
            end else if (r_out_vld && i_out_ready) begin
                if (r_pend_vld) begin
                    r_out      <= r_pend;
                    r_pend_vld <= 1'b0;
                end else begin
                    r_out_vld <= 1'b0;
                end
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Checks on chain occupancy, count bound and result slots.
    `ILE_ASSERT_NOW(a_one_token, 1'b1, $countones(w_chain_vld) <= 1, "two commands in the cell chain")
    `ILE_ASSERT_NOW(a_chain_busy, |w_chain_vld, r_busy, "token in the chain while engine is idle")
    `ILE_ASSERT_NOW(a_count_bound, 1'b1, w_cnt <= CAP_CNT, "element count above capacity")
    `ILE_ASSERT_NOW(a_pend_order, r_pend_vld, r_out_vld, "holding slot full with output register empty")
    `ILE_ASSERT_NEXT(a_exit_frees, w_exit, !r_busy, "engine still busy after result left the chain")

endmodule

>>> sim/indexed_list_engine_checker.sv
// Scoreboard for the list engine: predicts each result beat and compares it.
`timescale 1ns / 100ps

module indexed_list_engine_checker #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  ile_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  ile_pkg::t_out_item i_out_data,
    output int                 o_mismatch_count,
    output int                 o_pending
);

    // At most two commands are outstanding, in the chain or as waiting results.
    localparam int DUE_DEPTH = 8;

    // Shadow copy of the list contents and its length.
    logic [31:0] list_vals [CAPACITY];
    int unsigned list_len;

    // Results predicted for accepted commands, oldest first, in a ring.
    ile_pkg::t_out_item replies_due [DUE_DEPTH];
    int unsigned        due_head;
    int unsigned        due_tail;
    int unsigned        due_used;

    initial begin
        list_len         = 0;
        due_head         = 0;
        due_tail         = 0;
        due_used         = 0;
        o_mismatch_count = 0;
        o_pending        = 0;
    end

    // Opens a slot at the given index by shifting the tail up, then stores the value.
    function automatic void insert_at(int unsigned at, logic [31:0] v);
        for (int unsigned i = list_len; i > at; i--) begin
            list_vals[i] = list_vals[i - 1];
        end
        list_vals[at] = v;
        list_len++;
    endfunction

    // Takes the value at the given index out and closes the gap.
    function automatic logic [31:0] take_at(int unsigned at);
        logic [31:0] v;
        v = list_vals[at];
        for (int unsigned i = at; i + 1 < list_len; i++) begin
            list_vals[i] = list_vals[i + 1];
        end
        list_len--;
        return v;
    endfunction

    // Applies one command to the shadow list and returns the result it should produce.
    function automatic ile_pkg::t_out_item apply_command(ile_pkg::t_in_item cmd);
        ile_pkg::t_out_item res;
        res = '0;
        case (cmd.mode)
            ile_pkg::MODE_PUSH_BACK, ile_pkg::MODE_PUSH_FRONT: begin
                if (list_len >= CAPACITY) begin
                    res.status = ile_pkg::ST_FULL;
                end else begin
                    insert_at((cmd.mode == ile_pkg::MODE_PUSH_BACK) ? list_len : 0,
                              cmd.value);
                end
            end
            ile_pkg::MODE_INSERT: begin
                // Range is checked ahead of fullness.
                if (cmd.position > list_len) begin
                    res.status = ile_pkg::ST_RANGE;
                end else if (list_len >= CAPACITY) begin
                    res.status = ile_pkg::ST_FULL;
                end else begin
                    insert_at(cmd.position, cmd.value);
                end
            end
            ile_pkg::MODE_POP_BACK, ile_pkg::MODE_POP_FRONT: begin
                if (list_len == 0) begin
                    res.status = ile_pkg::ST_EMPTY;
                end else begin
                    res.data_out = take_at((cmd.mode == ile_pkg::MODE_POP_BACK) ?
                                           list_len - 1 : 0);
                end
            end
            ile_pkg::MODE_REMOVE: begin
                if (cmd.position >= list_len) begin
                    res.status = ile_pkg::ST_RANGE;
                end else begin
                    res.data_out = take_at(cmd.position);
                end
            end
            ile_pkg::MODE_SET: begin
                if (cmd.position >= list_len) begin
                    res.status = ile_pkg::ST_RANGE;
                end else begin
                    list_vals[cmd.position] = cmd.value;
                end
            end
            ile_pkg::MODE_GET: begin
                if (cmd.position >= list_len) begin
                    res.status = ile_pkg::ST_RANGE;
                end else begin
                    res.data_out = list_vals[cmd.position];
                end
            end
            ile_pkg::MODE_SEARCH: begin
                // Only the first match counts.
                for (int unsigned i = 0; i < list_len; i++) begin
                    if (!res.found && list_vals[i] == cmd.value) begin
                        res.found       = 1'b1;
                        res.found_index = i[3:0];
                    end
                end
            end
            ile_pkg::MODE_CLEAR: begin
                list_len = 0;
            end
            default: begin
                // Unused codes leave the list alone.
            end
        endcase
        res.count = list_len[4:0];
        return res;
    endfunction

    // Counts a failure and prints the first few of them.
    task automatic note_mismatch(string what, ile_pkg::t_out_item want,
                                 ile_pkg::t_out_item got);
        o_mismatch_count++;
        if (o_mismatch_count <= 10) begin
            $display("%0t ns: %s: expected st=%0d data=%h found=%0d idx=%0d cnt=%0d,",
                     $time, what, want.status, want.data_out, want.found,
                     want.found_index, want.count);
            $display("    got st=%0d data=%h found=%0d idx=%0d cnt=%0d",
                     got.status, got.data_out, got.found, got.found_index, got.count);
        end
    endtask

    // Result beats are checked before the command beat of the same edge is predicted;
    // the latency keeps a command from producing its own result in that cycle.
    always @(posedge i_clk) begin
        ile_pkg::t_out_item want;
        if (!i_rst_n) begin
            list_len = 0;
            due_head = 0;
            due_tail = 0;
            due_used = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (due_used == 0) begin
                    note_mismatch("result with no command waiting", '0, i_out_data);
                end else begin
                    want     = replies_due[due_head];
                    due_head = (due_head + 1) % DUE_DEPTH;
                    due_used--;
                    if (want.status != i_out_data.status ||
                        want.data_out != i_out_data.data_out ||
                        want.found != i_out_data.found ||
                        want.found_index != i_out_data.found_index ||
                        want.count != i_out_data.count) begin
                        note_mismatch("result mismatch", want, i_out_data);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (due_used == DUE_DEPTH) begin
                    note_mismatch("too many commands without a result", '0, '0);
                end else begin
                    replies_due[due_tail] = apply_command(i_in_data);
                    due_tail = (due_tail + 1) % DUE_DEPTH;
                    due_used++;
                end
            end
        end
        o_pending = due_used;
    end

endmodule

>>> sim/indexed_list_engine_test.sv
// Stimulus and verdict for the list engine, with the scoreboard beside the block.
`timescale 1ns / 100ps

module indexed_list_engine_test;

    localparam int          CAPACITY   = 16;
    localparam int          LATENCY    = CAPACITY + 2;
    localparam int          PHASE_LEN  = 525;
    localparam longint      LIMIT_NS   = 3_000_000;
    localparam logic [3:0]  MODE_SPARE_LO = 4'd10;
    localparam logic [3:0]  MODE_SPARE_HI = 4'd15;

    // Tendencies of the random command mix.
    localparam int TREND_GROW   = 0;
    localparam int TREND_SHRINK = 1;
    localparam int TREND_MIXED  = 2;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    ile_pkg::t_in_item  i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    ile_pkg::t_out_item o_out_data;

    int mismatch_count;
    int pending;
    int send_idle_pct = 31;
    int recv_idle_pct = 82;

    indexed_list_engine #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (32)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    indexed_list_engine_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_in_data        (i_in_data),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_out_data       (o_out_data),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(LIMIT_NS);
        $display("FAIL indexed_list_engine");
        $finish;
    end

    // Result side: ready drops at random at the current idle rate.
    initial begin
        forever begin
            @(posedge i_clk);
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Presents one command beat after a random gap and holds it until accepted.
    task automatic send_command(ile_pkg::t_in_item cmd);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= cmd;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic issue(logic [3:0] mode, logic [4:0] position, logic [31:0] value);
        ile_pkg::t_in_item cmd;
        cmd.mode     = mode;
        cmd.position = position;
        cmd.value    = value;
        send_command(cmd);
    endtask

    // Picks a command code; growing runs favour pushes and inserts, shrinking runs favour pops and removes.
    function automatic logic [3:0] pick_mode(int trend);
        int r;
        logic [3:0] m;
        r = $urandom_range(99);
        if (trend == TREND_GROW) begin
            if (r < 35)      m = ile_pkg::MODE_PUSH_BACK;
            else if (r < 55) m = ile_pkg::MODE_PUSH_FRONT;
            else if (r < 75) m = ile_pkg::MODE_INSERT;
            else if (r < 80) m = ile_pkg::MODE_POP_BACK;
            else if (r < 85) m = ile_pkg::MODE_REMOVE;
            else if (r < 90) m = ile_pkg::MODE_SET;
            else if (r < 94) m = ile_pkg::MODE_GET;
            else if (r < 98) m = ile_pkg::MODE_SEARCH;
            else             m = 4'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        end else if (trend == TREND_SHRINK) begin
            if (r < 25)      m = ile_pkg::MODE_POP_BACK;
            else if (r < 45) m = ile_pkg::MODE_POP_FRONT;
            else if (r < 65) m = ile_pkg::MODE_REMOVE;
            else if (r < 70) m = ile_pkg::MODE_PUSH_BACK;
            else if (r < 75) m = ile_pkg::MODE_INSERT;
            else if (r < 82) m = ile_pkg::MODE_GET;
            else if (r < 89) m = ile_pkg::MODE_SET;
            else if (r < 96) m = ile_pkg::MODE_SEARCH;
            else if (r < 98) m = ile_pkg::MODE_CLEAR;
            else             m = 4'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        end else begin
            m = 4'($urandom_range(15));
            // Keep clears rare so the list does not sit empty.
            if (m == ile_pkg::MODE_CLEAR && r < 75) m = ile_pkg::MODE_SEARCH;
        end
        return m;
    endfunction

    // Mostly in-range positions, sometimes anything the field can hold.
    function automatic logic [4:0] pick_position();
        if ($urandom_range(99) < 85) return 5'($urandom_range(CAPACITY));
        return 5'($urandom_range(31));
    endfunction

    // A small pool of values makes searches hit; the rest is full-width noise.
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 40) return 32'($urandom_range(7)) - 32'd3;
        if (r < 44) return 32'h8000_0000;
        if (r < 48) return 32'h7fff_ffff;
        return $urandom;
    endfunction

    // Random commands in runs of one tendency at a time.
    task automatic random_phase(int n_items);
        int trend;
        int run_left;
        ile_pkg::t_in_item cmd;
        trend    = TREND_MIXED;
        run_left = 0;
        for (int k = 0; k < n_items; k++) begin
            if (run_left == 0) begin
                trend    = $urandom_range(2);
                run_left = $urandom_range(20, 60);
            end
            run_left--;
            cmd.mode     = pick_mode(trend);
            cmd.position = pick_position();
            cmd.value    = pick_value();
            send_command(cmd);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: the pops, remove, set, get, search and insert on an empty list, then the boundaries of a small one.
        issue(ile_pkg::MODE_POP_BACK,   5'd0,  32'd0);
        issue(ile_pkg::MODE_POP_FRONT,  5'd0,  32'd0);
        issue(ile_pkg::MODE_REMOVE,     5'd0,  32'd0);
        issue(ile_pkg::MODE_SET,        5'd0,  32'd5);
        issue(ile_pkg::MODE_GET,        5'd0,  32'd0);
        issue(ile_pkg::MODE_SEARCH,     5'd0,  32'd0);
        issue(ile_pkg::MODE_INSERT,     5'd1,  32'd9);
        issue(ile_pkg::MODE_INSERT,     5'd0,  32'h8000_0000);
        issue(ile_pkg::MODE_PUSH_BACK,  5'd0,  32'h7fff_ffff);
        issue(ile_pkg::MODE_PUSH_FRONT, 5'd0,  32'hffff_ffff);
        issue(ile_pkg::MODE_INSERT,     5'd3,  32'd0);
        issue(ile_pkg::MODE_GET,        5'd31, 32'd0);
        issue(ile_pkg::MODE_GET,        5'd3,  32'd0);
        issue(ile_pkg::MODE_SEARCH,     5'd0,  32'h7fff_ffff);
        issue(ile_pkg::MODE_SEARCH,     5'd0,  32'h1234_5678);
        issue(ile_pkg::MODE_SET,        5'd1,  32'h5a5a_5a5a);
        issue(ile_pkg::MODE_REMOVE,     5'd2,  32'd0);
        issue(ile_pkg::MODE_POP_FRONT,  5'd0,  32'd0);
        issue(ile_pkg::MODE_POP_BACK,   5'd0,  32'd0);
        issue(MODE_SPARE_LO,            5'd16, 32'd0);
        issue(MODE_SPARE_HI,            5'd31, 32'hffff_ffff);
        issue(ile_pkg::MODE_CLEAR,      5'd0,  32'd0);
        issue(ile_pkg::MODE_PUSH_BACK,  5'd0,  32'd1);
        issue(ile_pkg::MODE_SEARCH,     5'd0,  32'd1);
        issue(ile_pkg::MODE_CLEAR,      5'd0,  32'd0);

        // Random: sender light and receiver heavy, then swapped, then no idling.
        random_phase(PHASE_LEN);
        send_idle_pct = 82;
        recv_idle_pct = 31;
        random_phase(PHASE_LEN);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(PHASE_LEN);
        i_in_valid <= 1'b0;

        // Drain, then leave room for any stray result beat.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3 * LATENCY) @(posedge i_clk);

        if (mismatch_count == 0 && pending == 0) begin
            $display("PASS indexed_list_engine");
        end else begin
            $display("FAIL indexed_list_engine");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/ile_pkg.sv
sv/ile_cell.sv
sv/indexed_list_engine.sv
sim/indexed_list_engine_checker.sv
sim/indexed_list_engine_test.sv
